// ===== rtl/core/osq_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered sequence store package
// Request codes, cell operations and the transfer payload types.
// ----------------------------------------------------------------------------
package osq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned CountW = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_REMOVE     = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [ValueW-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ReqW-1:0]           req_type;
    logic signed [ValueW-1:0]  value;
  } in_t;

  typedef struct packed {
    logic                      ok;
    logic [CountW-1:0]         count;
    logic                      front_valid;
    logic signed [ValueW-1:0]  front_value;
  } out_t;

endpackage

// ===== rtl/core/ordered_sequence_store.sv =====
// ----------------------------------------------------------------------------
// Ordered sequence store
// Bounded sequence of signed values held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Every request is resolved combinationally in the cells, so the block takes
// one transfer per cycle while the result register is free or being drained.
// All cells see the request at once; the first cell whose compare matches
// starts a carry that ripples down the chain, and every cell behind it shifts
// toward or away from the front to open or close a gap. The carry through all
// CAPACITY cells is the longest path. One result transfer follows each
// request, with the status, the count and the front element after it.
module ordered_sequence_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  osq_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output osq_pkg::out_t  out_o
);
  import osq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     ok;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;
  logic [CntW+CountW-1:0]   count_ext;
  cell_ctrl_t               ctrl;
  logic                     out_valid_q;
  logic                     out_valid_d;
  out_t                     out_q;
  out_t                     out_d;

  logic signed [ValueW-1:0] cell_value [CAPACITY];
  logic signed [ValueW-1:0] cell_next  [CAPACITY];
  logic                     carry      [CAPACITY+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q == CntW'(CAPACITY);
  assign empty      = count_q == '0;

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_i.value;
    if (accept) begin
      unique case (req_e'(in_i.req_type))
        REQ_PUSH_FRONT: begin
          if (!full) ctrl.op = CELL_SHIFT_IN;
        end
        REQ_PUSH_BACK: begin
          if (!full) ctrl.op = CELL_APPEND;
        end
        REQ_POP_FRONT: begin
          if (!empty) ctrl.op = CELL_SHIFT_OUT;
        end
        REQ_INSERT: begin
          if (!full) ctrl.op = CELL_INSERT;
        end
        REQ_REMOVE: begin
          ctrl.op = CELL_REMOVE;
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  always_comb begin
    ok      = 1'b0;
    count_d = count_q;
    if (accept) begin
      unique case (req_e'(in_i.req_type))
        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
          if (!full) begin
            ok      = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (!empty) begin
            ok      = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        REQ_REMOVE: begin
          ok = carry[CAPACITY];
          if (carry[CAPACITY]) count_d = count_q - 1'b1;
        end
        REQ_CLEAR: begin
          ok      = 1'b1;
          count_d = '0;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign carry[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValueW-1:0] left;
    logic signed [ValueW-1:0] right;

    if (g == 0) begin : g_first
      assign left = in_i.value;
    end else begin : g_mid
      assign left = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = in_i.value;
    end else begin : g_inner
      assign right = cell_value[g+1];
    end

    osq_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_i       (left),
      .right_i      (right),
      .carry_i      (carry[g]),
      .carry_o      (carry[g+1]),
      .value_o      (cell_value[g]),
      .value_next_o (cell_next[g])
    );
  end

  assign count_ext = {{CountW{1'b0}}, count_d};

  always_comb begin
    out_d.ok          = ok;
    out_d.count       = count_ext[CountW-1:0];
    out_d.front_valid = count_d != '0;
    out_d.front_value = (count_d != '0) ? cell_next[0] : '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/osq_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered sequence store cell
// One stored element with its compare logic and a link to both neighbors.
// ----------------------------------------------------------------------------
module osq_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                               clk_i,
  input  osq_pkg::cell_ctrl_t                ctrl_i,
  input  logic [CntW-1:0]                    count_i,
  input  logic signed [osq_pkg::ValueW-1:0]  left_i,
  input  logic signed [osq_pkg::ValueW-1:0]  right_i,
  input  logic                               carry_i,
  output logic                               carry_o,
  output logic signed [osq_pkg::ValueW-1:0]  value_o,
  output logic signed [osq_pkg::ValueW-1:0]  value_next_o
);
  import osq_pkg::*;

  logic                     occ;
  logic                     hit;
  logic signed [ValueW-1:0] value_q;
  logic signed [ValueW-1:0] value_d;

  assign occ = CntW'(Index) < count_i;

  always_comb begin
    case (ctrl_i.op)
      CELL_INSERT: hit = occ && (ctrl_i.value < value_q);
      CELL_REMOVE: hit = occ && (ctrl_i.value == value_q);
      default:     hit = 1'b0;
    endcase
  end

  assign carry_o = carry_i | hit;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_SHIFT_IN:  value_d = left_i;
      CELL_SHIFT_OUT: value_d = right_i;
      CELL_APPEND: begin
        if (!occ) value_d = ctrl_i.value;
      end
      CELL_INSERT: begin
        if (carry_i) begin
          value_d = left_i;
        end else if (hit || !occ) begin
          value_d = ctrl_i.value;
        end
      end
      CELL_REMOVE: begin
        if (carry_i || hit) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o      = value_q;
  assign value_next_o = value_d;

endmodule
